[rtl/core/pcru_pkg.sv]
// pcru_pkg: widths, register indexes and types for the pointer clamp block
// no dependencies; imported by the clamp unit, the core and the checker
package pcru_pkg;

    localparam int FRAC_BITS = 8;
    localparam int MAX_RECTS = 6;
    localparam int POS_W     = 26;
    localparam int DELTA_W   = 24;
    localparam int MAG_W     = 26;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int DIST_W    = SQ_W + 1;
    localparam int IDX_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    // configuration register indexes beyond the rectangle table
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_COUNT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKED     = 3'd7;

    // reset layout: 1920x1080 at the origin, cursor at its center
    localparam logic [CFG_W-1:0]        RECT0_RESET = 64'h0438_0780_0000_0000;
    localparam logic signed [POS_W-1:0] CUR_X_RESET = 26'sd245760;
    localparam logic signed [POS_W-1:0] CUR_Y_RESET = 26'sd138240;

    typedef logic signed [POS_W-1:0] t_pos;

    // packed rectangle, same bit layout as the configuration word
    typedef struct packed {
        logic [15:0]        h;
        logic [15:0]        w;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_rect;

    // projection of a point onto one rectangle
    typedef struct packed {
        t_pos             cx;
        t_pos             cy;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
    } t_clamp_res;

endpackage

[rtl/core/pcru_clamp.sv]
// pcru_clamp: projects a point onto one rectangle, per axis clamp and error magnitude
// depends on pcru_pkg
module pcru_clamp import pcru_pkg::*; (
    input  t_rect      i_rect,
    input  t_pos       i_px,
    input  t_pos       i_py,
    output t_clamp_res o_res
);

    // clamp one axis to [lo, lo + size - 1/256], return clamped value and |v - c|
    function automatic logic [POS_W+MAG_W-1:0] clamp_axis(
        input logic signed [15:0] org,
        input logic [15:0]        size,
        input t_pos               v
    );
        logic signed [POS_W:0] lo;
        logic signed [POS_W:0] top;
        logic signed [POS_W:0] vv;
        logic signed [POS_W:0] c;
        logic signed [POS_W:0] e;
        logic signed [POS_W:0] m;
        lo  = signed'({{3{org[15]}}, org, 8'b0});
        top = lo + signed'({3'b0, size, 8'b0}) - 27'sd1;
        vv  = {v[POS_W-1], v};
        if (vv < lo) begin
            c = lo;
        end else if (vv > top) begin
            c = top;
        end else begin
            c = vv;
        end
        e = vv - c;
        m = e[POS_W] ? -e : e;
        return {c[POS_W-1:0], m[MAG_W-1:0]};
    endfunction

    logic [POS_W+MAG_W-1:0] res_x;
    logic [POS_W+MAG_W-1:0] res_y;

    // both axes side by side
    always_comb begin
        res_x    = clamp_axis(i_rect.x, i_rect.w, i_px);
        res_y    = clamp_axis(i_rect.y, i_rect.h, i_py);
        o_res.cx = res_x[POS_W+MAG_W-1:MAG_W];
        o_res.ax = res_x[MAG_W-1:0];
        o_res.cy = res_y[POS_W+MAG_W-1:MAG_W];
        o_res.ay = res_y[MAG_W-1:0];
    end

endmodule

[rtl/core/pointer_clamp_rect_union_core.sv]
// pointer_clamp_rect_union_core: cursor clamp to a union of up to six rectangles
// depends on pcru_pkg and pcru_clamp
//
// Keeps the cursor in signed fixed point (8 fraction bits) and returns one
// position per input transfer. A motion transfer walks the active rectangles
// one at a time through a single clamp unit and one shared 26x26 squarer:
// each rectangle passes through the clamp, square x, square y and compare
// states in turn. A locked pointer or an empty table skips the walk. A
// layout transfer runs the containment check one rectangle per cycle. The
// input is stalled from acceptance until the result enters the output
// register; that register lets the next input transfer be accepted while
// the previous result still waits downstream. Configuration is taken in
// every cycle (ready is tied high) and must only be written while idle.
module pointer_clamp_rect_union_core import pcru_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic signed [DELTA_W-1:0]   i_delta_x,
    input  logic signed [DELTA_W-1:0]   i_delta_y,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [POS_W-1:0]     o_cursor_x,
    output logic signed [POS_W-1:0]     o_cursor_y,
    // configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLAMP = 3'd1;
    localparam logic [2:0] S_SQX   = 3'd2;
    localparam logic [2:0] S_SQY   = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [IDX_W-1:0] LAST_MAX = IDX_W'(MAX_RECTS - 1);

    logic [CFG_W-1:0]  r_rect [MAX_RECTS];
    logic [2:0]        r_rect_count;
    logic              r_locked;
    t_pos              r_cur_x;
    t_pos              r_cur_y;
    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [IDX_W-1:0]  r_idx;
    logic              r_layout;
    t_pos              r_tx;
    t_pos              r_ty;
    t_pos              r_cx;
    t_pos              r_cy;
    logic [MAG_W-1:0]  r_ax;
    logic [MAG_W-1:0]  r_ay;
    logic [SQ_W-1:0]   r_sqx;
    logic [SQ_W-1:0]   r_sqy;
    logic [DIST_W-1:0] r_best;
    logic              r_have;
    t_pos              r_bx;
    t_pos              r_by;
    logic              r_out_valid;
    t_pos              r_out_x;
    t_pos              r_out_y;

    logic              in_xfer;
    logic              no_rects;
    logic [IDX_W-1:0]  last_idx;
    logic              is_last;
    logic [POS_W:0]    sum_x;
    logic [POS_W:0]    sum_y;
    t_pos              sat_x;
    t_pos              sat_y;
    t_rect             cur_rect;
    t_rect             rect0;
    t_clamp_res        clamp_res;
    logic [MAG_W-1:0]  mul_a;
    logic [SQ_W-1:0]   mul_p;
    logic [DIST_W-1:0] dist_sum;
    logic              take;
    logic              in_rect;
    logic              out_load;
    t_pos              seat_x;
    t_pos              seat_y;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_cursor_x  = r_out_x;
    assign o_cursor_y  = r_out_y;
    assign in_xfer     = i_in_valid && !o_in_stall;

    // active rectangle count, saturated to the table size
    assign no_rects = (r_rect_count == 3'd0);
    assign last_idx = (r_rect_count > 3'(MAX_RECTS)) ? LAST_MAX
                                                     : IDX_W'(r_rect_count - 3'd1);
    assign is_last  = (r_idx == last_idx);

    // saturating cursor plus delta
    always_comb begin
        sum_x = {r_cur_x[POS_W-1], r_cur_x} + {{3{i_delta_x[DELTA_W-1]}}, i_delta_x};
        sum_y = {r_cur_y[POS_W-1], r_cur_y} + {{3{i_delta_y[DELTA_W-1]}}, i_delta_y};
        if (sum_x[POS_W] != sum_x[POS_W-1]) begin
            sat_x = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            sat_x = sum_x[POS_W-1:0];
        end
        if (sum_y[POS_W] != sum_y[POS_W-1]) begin
            sat_y = sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            sat_y = sum_y[POS_W-1:0];
        end
    end

    // shared clamp unit on the selected rectangle
    assign cur_rect = t_rect'(r_rect[r_idx]);

    pcru_clamp u_clamp (
        .i_rect (cur_rect),
        .i_px   (r_tx),
        .i_py   (r_ty),
        .o_res  (clamp_res)
    );

    assign in_rect = (clamp_res.ax == '0) && (clamp_res.ay == '0);

    // shared squarer, x then y
    assign mul_a = (r_state == S_SQX) ? r_ax : r_ay;
    assign mul_p = mul_a * mul_a;

    // distance compare, the earlier rectangle wins ties
    assign dist_sum = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign take     = !r_have || (dist_sum < r_best);

    // reseat point: center of the first rectangle
    assign rect0  = t_rect'(r_rect[0]);
    assign seat_x = t_pos'({{2{rect0.x[15]}}, rect0.x, 8'b0}) + t_pos'({3'b0, rect0.w, 7'b0});
    assign seat_y = t_pos'({{2{rect0.y[15]}}, rect0.y, 8'b0}) + t_pos'({3'b0, rect0.h, 7'b0});

    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (no_rects || (!i_op && r_locked)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CLAMP;
                    end
                end
            end
            S_CLAMP: begin
                if (!r_layout) begin
                    n_state = S_SQX;
                end else if (in_rect || is_last) begin
                    n_state = S_DONE;
                end
            end
            S_SQX: n_state = S_SQY;
            S_SQY: n_state = S_CMP;
            S_CMP: n_state = is_last ? S_DONE : S_CLAMP;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state, configuration and cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_rect_count <= 3'd1;
            r_locked     <= 1'b0;
            r_cur_x      <= CUR_X_RESET;
            r_cur_y      <= CUR_Y_RESET;
            r_have       <= 1'b0;
            r_idx        <= '0;
            r_layout     <= 1'b0;
            for (int i = 0; i < MAX_RECTS; i++) begin
                r_rect[i] <= (i == 0) ? RECT0_RESET : '0;
            end
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RECT_COUNT: r_rect_count <= i_cfg_data[2:0];
                    CFG_LOCKED:     r_locked     <= i_cfg_data[0];
                    default: begin
                        if (i_cfg_index < CFG_IDX_W'(MAX_RECTS)) begin
                            r_rect[IDX_W'(i_cfg_index)] <= i_cfg_data;
                        end
                    end
                endcase
            end

            // item start
            if (in_xfer) begin
                r_idx    <= '0;
                r_have   <= 1'b0;
                r_layout <= i_op;
            end

            // containment walk for a layout transfer
            if (r_state == S_CLAMP && r_layout) begin
                if (!in_rect && is_last) begin
                    r_cur_x <= seat_x;
                    r_cur_y <= seat_y;
                end else if (!in_rect) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end

            // best-candidate update, commit after the last rectangle
            if (r_state == S_CMP) begin
                r_have <= 1'b1;
                if (is_last) begin
                    r_cur_x <= take ? r_cx : r_bx;
                    r_cur_y <= take ? r_cy : r_by;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end

            // result register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_tx <= i_op ? r_cur_x : sat_x;
            r_ty <= i_op ? r_cur_y : sat_y;
        end
        if (r_state == S_CLAMP) begin
            r_cx <= clamp_res.cx;
            r_cy <= clamp_res.cy;
            r_ax <= clamp_res.ax;
            r_ay <= clamp_res.ay;
        end
        if (r_state == S_SQX) begin
            r_sqx <= mul_p;
        end
        if (r_state == S_SQY) begin
            r_sqy <= mul_p;
        end
        if (r_state == S_CMP && take) begin
            r_best <= dist_sum;
            r_bx   <= r_cx;
            r_by   <= r_cy;
        end
        if (out_load) begin
            r_out_x <= r_cur_x;
            r_out_y <= r_cur_y;
        end
    end

endmodule

[rtl/core/pcru_checker.sv]
// pcru_checker: port-level checks for pointer_clamp_rect_union_core, bound to the top
// depends on pcru_pkg and pointer_clamp_rect_union_core
module pcru_checker import pcru_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      i_op,
    input logic signed [DELTA_W-1:0] i_delta_x,
    input logic signed [DELTA_W-1:0] i_delta_y,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [POS_W-1:0]   o_cursor_x,
    input logic signed [POS_W-1:0]   o_cursor_y,
    input logic                      i_cfg_valid,
    input logic                      o_cfg_ready,
    input logic [CFG_IDX_W-1:0]      i_cfg_index,
    input logic [CFG_W-1:0]          i_cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_x)
            && $stable(o_cursor_y))
        else $error("result changed while stalled");

    // a stalled input transfer holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_op)
            && $stable(i_delta_x) && $stable(i_delta_y))
        else $error("input changed while stalled");

    // an accepted input transfer makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    // a new result only follows a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work");

    // configuration transfers only while idle, with known contents
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |-> !o_in_stall
            && !$isunknown({i_cfg_index, i_cfg_data}))
        else $error("configuration written while busy");

endmodule

bind pointer_clamp_rect_union_core pcru_checker u_pcru_checker (.*);
